// ===== rtl/arprc_pkg.sv =====
// shared types and constants for the arp responder with address cache
package arprc_pkg;

    // cache geometry
    localparam int CACHE_ENTRIES = 16;
    localparam int CACHE_IDX_W   = $clog2(CACHE_ENTRIES);
    localparam int CACHE_CNT_W   = $clog2(CACHE_ENTRIES + 1);

    // field widths
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 136;

    // packet field values
    localparam logic [15:0] HW_TYPE_ETH     = 16'h0001;
    localparam logic [7:0]  HW_SIZE_ETH     = 8'd6;
    localparam logic [15:0] PROTO_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_SIZE_IPV4 = 8'd4;
    localparam logic [15:0] OPC_REQUEST     = 16'd1;
    localparam logic [15:0] OPC_REPLY       = 16'd2;

    localparam logic [1:0] TX_OPC_NONE    = 2'd0;
    localparam logic [1:0] TX_OPC_REQUEST = 2'd1;
    localparam logic [1:0] TX_OPC_REPLY   = 2'd2;

    localparam logic [MAC_W-1:0] BCAST_MAC = {(MAC_W/8){8'hff}};

    // request kinds carried on s_tuser
    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    // configuration register indexes
    localparam logic CFG_LOCAL_IP  = 1'b0;
    localparam logic CFG_LOCAL_MAC = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_MISS       = 3'd1,
        ST_ANSWERED   = 3'd2,
        ST_REPLY_OK   = 3'd3,
        ST_NOT_OURS   = 3'd4,
        ST_BAD_HW     = 3'd5,
        ST_BAD_PROTO  = 3'd6,
        ST_BAD_OPCODE = 3'd7
    } arp_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_SCAN,
        S_UPDATE,
        S_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic        load;
        logic        scan_clear;
        logic        scan;
        logic        refresh;
        logic        insert;
        logic        emit;
        arp_status_t code;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_resolve;
        logic hw_ok;
        logic proto_ok;
        logic ours;
        logic opc_request;
        logic opc_reply;
        logic hit;
        logic last;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/arprc_ctrl.sv =====
// controller state machine sequencing classify, cache scan, update and result
module arprc_ctrl
    import arprc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        merged_reg, merged_next;
    arp_status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            merged_reg <= 1'b0;
            code_reg   <= ST_HIT;
        end else begin
            state_reg  <= state_next;
            merged_reg <= merged_next;
            code_reg   <= code_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        merged_next    = merged_reg;
        code_next      = code_reg;
        s_tready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.scan_clear = 1'b0;
        cmd.scan       = 1'b0;
        cmd.refresh    = 1'b0;
        cmd.insert     = 1'b0;
        cmd.emit       = 1'b0;
        cmd.code       = code_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                cmd.scan_clear = 1'b1;
                if (stat.is_resolve) begin
                    state_next = S_SCAN;
                end else if (!stat.hw_ok) begin
                    code_next  = ST_BAD_HW;
                    state_next = S_EMIT;
                end else if (!stat.proto_ok) begin
                    code_next  = ST_BAD_PROTO;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit) begin
                    merged_next = 1'b1;
                    if (stat.is_resolve) begin
                        code_next  = ST_HIT;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_UPDATE;
                    end
                end else if (stat.last) begin
                    merged_next = 1'b0;
                    if (stat.is_resolve) begin
                        code_next  = ST_MISS;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                cmd.refresh = merged_reg;
                cmd.insert  = !merged_reg && stat.ours;
                if (!stat.ours) begin
                    code_next = ST_NOT_OURS;
                end else if (stat.opc_request) begin
                    code_next = ST_ANSWERED;
                end else if (stat.opc_reply) begin
                    code_next = ST_REPLY_OK;
                end else begin
                    code_next = ST_BAD_OPCODE;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/arprc_dp.sv =====
// datapath: request and config registers, address cache, scan pipeline, result register
module arprc_dp
    import arprc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [MAC_W-1:0]     cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  dp_cmd_t              cmd,
    output dp_status_t           stat
);

    // configuration
    logic [IP_W-1:0] local_ip_reg;

    // captured request
    logic             op_reg;
    logic [15:0]      hw_type_reg;
    logic [7:0]       hw_size_reg;
    logic [15:0]      proto_type_reg;
    logic [7:0]       proto_size_reg;
    logic [15:0]      arp_opcode_reg;
    logic [IP_W-1:0]  sender_ip_reg;
    logic [MAC_W-1:0] sender_mac_reg;
    logic [IP_W-1:0]  target_ip_reg;
    logic [IP_W-1:0]  query_ip_reg;

    // cache
    logic [IP_W-1:0]          mem_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0]         mem_mac [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] slot_valid_reg;
    logic [CACHE_IDX_W-1:0]   fill_ptr_reg;

    // scan pipeline
    logic [CACHE_CNT_W-1:0] scan_cnt_reg;
    logic [IP_W-1:0]        rd_ip_reg;
    logic [MAC_W-1:0]       rd_mac_reg;
    logic [CACHE_IDX_W-1:0] rd_idx_reg;
    logic                   rd_live_reg;
    logic [CACHE_IDX_W-1:0] hit_idx_reg;
    logic [MAC_W-1:0]       hit_mac_reg;

    // result
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic [IP_W-1:0]        key_ip;
    logic                   scan_issue;
    logic                   hit;
    logic [CACHE_IDX_W-1:0] wr_idx;
    logic [CACHE_IDX_W-1:0] fill_ptr_next;

    assign key_ip     = (op_reg == OP_RESOLVE) ? query_ip_reg : sender_ip_reg;
    assign scan_issue = cmd.scan && (scan_cnt_reg < CACHE_CNT_W'(CACHE_ENTRIES));
    assign hit        = rd_live_reg && slot_valid_reg[rd_idx_reg] && (rd_ip_reg == key_ip);
    assign wr_idx     = cmd.insert ? fill_ptr_reg : hit_idx_reg;
    assign fill_ptr_next = (fill_ptr_reg == CACHE_IDX_W'(CACHE_ENTRIES - 1)) ?
                           '0 : fill_ptr_reg + 1'b1;

    always_comb begin
        stat.is_resolve  = (op_reg == OP_RESOLVE);
        stat.hw_ok       = (hw_type_reg == HW_TYPE_ETH) && (hw_size_reg == HW_SIZE_ETH);
        stat.proto_ok    = (proto_type_reg == PROTO_TYPE_IPV4) &&
                           (proto_size_reg == PROTO_SIZE_IPV4);
        stat.ours        = (target_ip_reg == local_ip_reg);
        stat.opc_request = (arp_opcode_reg == OPC_REQUEST);
        stat.opc_reply   = (arp_opcode_reg == OPC_REPLY);
        stat.hit         = hit;
        stat.last        = rd_live_reg && (rd_idx_reg == CACHE_IDX_W'(CACHE_ENTRIES - 1));
        stat.out_busy    = m_tvalid_reg && !m_tready;
    end

    // config writes; local mac is only the sender of outgoing frames and is not kept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg <= '0;
        end else if (cfg_wr_en && (cfg_index == CFG_LOCAL_IP)) begin
            local_ip_reg <= cfg_wdata[IP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= s_tuser[0];
            hw_type_reg    <= s_tdata[15:0];
            hw_size_reg    <= s_tdata[23:16];
            proto_type_reg <= s_tdata[39:24];
            proto_size_reg <= s_tdata[47:40];
            arp_opcode_reg <= s_tdata[63:48];
            sender_ip_reg  <= s_tdata[95:64];
            sender_mac_reg <= s_tdata[143:96];
            target_ip_reg  <= s_tdata[175:144];
            query_ip_reg   <= s_tdata[207:176];
        end
    end

    // cache memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            mem_ip[wr_idx] <= sender_ip_reg;
        end
        if (cmd.insert || cmd.refresh) begin
            mem_mac[wr_idx] <= sender_mac_reg;
        end
        if (scan_issue) begin
            rd_ip_reg  <= mem_ip[scan_cnt_reg[CACHE_IDX_W-1:0]];
            rd_mac_reg <= mem_mac[scan_cnt_reg[CACHE_IDX_W-1:0]];
            rd_idx_reg <= scan_cnt_reg[CACHE_IDX_W-1:0];
        end
        if (cmd.scan && hit) begin
            hit_idx_reg <= rd_idx_reg;
            hit_mac_reg <= rd_mac_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            fill_ptr_reg   <= '0;
            scan_cnt_reg   <= '0;
            rd_live_reg    <= 1'b0;
        end else begin
            if (cmd.insert) begin
                slot_valid_reg[fill_ptr_reg] <= 1'b1;
                fill_ptr_reg                 <= fill_ptr_next;
            end
            if (cmd.scan_clear) begin
                scan_cnt_reg <= '0;
                rd_live_reg  <= 1'b0;
            end else if (cmd.scan) begin
                rd_live_reg <= scan_issue;
                if (scan_issue) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb begin
        m_tdata_next      = '0;
        m_tdata_next[2:0] = cmd.code;
        case (cmd.code)
            ST_HIT: begin
                m_tdata_next[50:3] = hit_mac_reg;
            end
            ST_MISS: begin
                m_tdata_next[51]      = 1'b1;
                m_tdata_next[53:52]   = TX_OPC_REQUEST;
                m_tdata_next[101:54]  = BCAST_MAC;
                m_tdata_next[133:102] = query_ip_reg;
            end
            ST_ANSWERED: begin
                m_tdata_next[51]      = 1'b1;
                m_tdata_next[53:52]   = TX_OPC_REPLY;
                m_tdata_next[101:54]  = sender_mac_reg;
                m_tdata_next[133:102] = sender_ip_reg;
            end
            default: begin
                m_tdata_next[53:52] = TX_OPC_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> !cmd.refresh)
        else $error("insert and refresh in the same cycle");

    a_insert_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> slot_valid_reg[$past(fill_ptr_reg)])
        else $error("inserted slot not marked valid");

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten before it was taken");

    a_tx_only_on_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[51]) |->
            (m_tdata_reg[2:0] == ST_MISS || m_tdata_reg[2:0] == ST_ANSWERED))
        else $error("tx flagged for a status that sends nothing");
`endif

endmodule

// ===== rtl/arp_responder_with_cache_top.sv =====
// top level of the arp responder with address cache
//
// Handles one request at a time. A request on s_tuser = 0 is a received arp
// packet, s_tuser = 1 a resolve query; every request yields exactly one
// result on the m_ side. A request is taken in S_IDLE and classified in
// S_CLASSIFY, then the address cache (CACHE_ENTRIES slots, 16 here) is
// scanned one slot per cycle through its single registered read port,
// stopping at the lowest matching valid slot. A packet then passes through
// S_UPDATE for the cache write (refresh of a known sender, or round-robin
// insert of a new one when the packet targets local_ip), and the result is
// loaded into the output register. A resolve query skips the cache write,
// the scan ends early on a hit, and a packet that fails the hardware or
// protocol check skips both the scan and the cache write. The output
// register lets the next request be accepted while a result is still
// waiting to be taken. No clearing pass is needed after reset: slot valid
// bits clear at once. local_mac is write-only and not used by this block
// since only the sender fields of outgoing frames would carry it.
module arp_responder_with_cache_top
    import arprc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port: index 0 local_ip, index 1 local_mac
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [MAC_W-1:0]     cfg_wdata,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // hw_type[15:0], hw_size[23:16], proto_type[39:24], proto_size[47:40],
    // arp_opcode[63:48], sender_ip[95:64], sender_mac[143:96],
    // target_ip[175:144], query_ip[207:176]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[0]: 0 received packet, 1 resolve query
    input  logic [0:0]           s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[2:0], resolved_mac[50:3], tx_valid[51], tx_opcode[53:52],
    // tx_target_mac[101:54], tx_target_ip[133:102], zero[135:134]
    output logic [M_TDATA_W-1:0] m_tdata
);

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t stat;

    // sequencer: classify, scan, cache write, hand-off to output register
    arprc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // request registers, cache, scan compare and result register
    arprc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== test/tb_arp_responder_with_cache_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the arp responder with address cache

import arprc_pkg::*;

// one request as the block sees it, before packing
typedef struct {
    logic             op;
    logic [15:0]      hw_type;
    logic [7:0]       hw_size;
    logic [15:0]      proto_type;
    logic [7:0]       proto_size;
    logic [15:0]      arp_opcode;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  target_ip;
    logic [IP_W-1:0]  query_ip;
} arp_request_t;

typedef struct {
    arp_status_t      status;
    logic [MAC_W-1:0] resolved_mac;
    logic             tx_valid;
    logic [1:0]       tx_opcode;
    logic [MAC_W-1:0] tx_target_mac;
    logic [IP_W-1:0]  tx_target_ip;
} arp_result_t;

// own copy of the address cache and registers, plus the results still owed
class arp_scoreboard;
    logic [IP_W-1:0]  local_ip;
    logic [MAC_W-1:0] local_mac;
    bit               slot_used [CACHE_ENTRIES];
    logic [IP_W-1:0]  slot_addr [CACHE_ENTRIES];
    logic [MAC_W-1:0] slot_hw   [CACHE_ENTRIES];
    int               next_slot;
    arp_result_t      awaited_results [$];
    int               errors;

    function new();
        local_ip  = '0;
        local_mac = '0;
        next_slot = 0;
        errors    = 0;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    // lowest valid slot holding this address, or -1
    function int lookup(logic [IP_W-1:0] ip);
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (slot_used[i] && slot_addr[i] == ip) return i;
        end
        return -1;
    endfunction

    function void note_request(arp_request_t r);
        arp_result_t res;
        int          idx;
        res.status        = ST_HIT;
        res.resolved_mac  = '0;
        res.tx_valid      = 1'b0;
        res.tx_opcode     = TX_OPC_NONE;
        res.tx_target_mac = '0;
        res.tx_target_ip  = '0;
        if (r.op == OP_RESOLVE) begin
            idx = lookup(r.query_ip);
            if (idx >= 0) begin
                res.resolved_mac = slot_hw[idx];
            end else begin
                res.status        = ST_MISS;
                res.tx_valid      = 1'b1;
                res.tx_opcode     = TX_OPC_REQUEST;
                res.tx_target_mac = BCAST_MAC;
                res.tx_target_ip  = r.query_ip;
            end
        end else if (!(r.hw_type == HW_TYPE_ETH && r.hw_size == HW_SIZE_ETH)) begin
            res.status = ST_BAD_HW;
        end else if (!(r.proto_type == PROTO_TYPE_IPV4 && r.proto_size == PROTO_SIZE_IPV4)) begin
            res.status = ST_BAD_PROTO;
        end else begin
            idx = lookup(r.sender_ip);
            if (idx >= 0) slot_hw[idx] = r.sender_mac;
            if (r.target_ip != local_ip) begin
                res.status = ST_NOT_OURS;
            end else begin
                if (idx < 0) begin
                    slot_used[next_slot] = 1'b1;
                    slot_addr[next_slot] = r.sender_ip;
                    slot_hw[next_slot]   = r.sender_mac;
                    next_slot = (next_slot + 1) % CACHE_ENTRIES;
                end
                if (r.arp_opcode == OPC_REQUEST) begin
                    res.status        = ST_ANSWERED;
                    res.tx_valid      = 1'b1;
                    res.tx_opcode     = TX_OPC_REPLY;
                    res.tx_target_mac = r.sender_mac;
                    res.tx_target_ip  = r.sender_ip;
                end else if (r.arp_opcode == OPC_REPLY) begin
                    res.status = ST_REPLY_OK;
                end else begin
                    res.status = ST_BAD_OPCODE;
                end
            end
        end
        awaited_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] d);
        arp_result_t e;
        if (awaited_results.size() == 0) begin
            $error("result with no request outstanding: 0x%0h", d);
            errors++;
            return;
        end
        e = awaited_results.pop_front();
        compare_field("status", 64'(e.status), 64'(d[2:0]));
        compare_field("resolved_mac", 64'(e.resolved_mac), 64'(d[50:3]));
        compare_field("tx_valid", 64'(e.tx_valid), 64'(d[51]));
        compare_field("tx_opcode", 64'(e.tx_opcode), 64'(d[53:52]));
        compare_field("tx_target_mac", 64'(e.tx_target_mac), 64'(d[101:54]));
        compare_field("tx_target_ip", 64'(e.tx_target_ip), 64'(d[133:102]));
    endfunction
endclass

module tb_arp_responder_with_cache_top;

    // cycles without any handshake before the run is abandoned
    localparam int QUIET_LIMIT     = 5000;
    localparam int POOL_SIZE       = 24;
    localparam int ITEMS_PER_PHASE = 205;
    // a full scan plus margin, let pass before register writes and at the end
    localparam int DRAIN_CYCLES    = CACHE_ENTRIES + 10;
    localparam logic [IP_W-1:0]  HOME_IP  = 32'hc0a8_0a01;
    localparam logic [MAC_W-1:0] HOME_MAC = 48'h0200_5e10_0001;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = CFG_LOCAL_IP;
    logic [MAC_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    arp_scoreboard sb = new();

    // percentages of cycles in which the sender idles or the receiver stalls
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    // addresses that recur, more of them than cache slots so that the
    // round-robin replacement gets exercised
    logic [IP_W-1:0] ip_pool [POOL_SIZE];

    arp_responder_with_cache_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure, and every taken result is checked
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // watchdog: counts cycles in which neither channel moves anything
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("tb_arp_responder_with_cache_top: errors");
        $finish;
    end

    // offer one request, with random idle cycles ahead of it, and hold it
    // until the block takes it; valid stays high when no gap follows
    task automatic send_request(arp_request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {r.query_ip, r.target_ip, r.sender_mac, r.sender_ip, r.arp_opcode,
                     r.proto_size, r.proto_type, r.hw_size, r.hw_type};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(r);
    endtask

    // both registers, back to back, while the block is idle
    task automatic set_addresses(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LOCAL_IP;
        cfg_wdata <= {{(MAC_W-IP_W){1'b0}}, ip};
        @(posedge aclk);
        cfg_index <= CFG_LOCAL_MAC;
        cfg_wdata <= mac;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.local_ip  = ip;
        sb.local_mac = mac;
    endtask

    // stop offering, wait for every owed result, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return w[MAC_W-1:0];
        endcase
    endfunction

    function automatic logic [IP_W-1:0] pick_ip();
        if ($urandom_range(99) < 85) return ip_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // well-formed packet; unused query field still random so its bits move
    function automatic arp_request_t packet(logic [15:0] opc, logic [IP_W-1:0] sip,
                                            logic [MAC_W-1:0] smac, logic [IP_W-1:0] tip);
        arp_request_t r;
        r.op         = OP_PACKET;
        r.hw_type    = HW_TYPE_ETH;
        r.hw_size    = HW_SIZE_ETH;
        r.proto_type = PROTO_TYPE_IPV4;
        r.proto_size = PROTO_SIZE_IPV4;
        r.arp_opcode = opc;
        r.sender_ip  = sip;
        r.sender_mac = smac;
        r.target_ip  = tip;
        r.query_ip   = $urandom();
        return r;
    endfunction

    // resolve query; packet fields carry random rubbish that must be ignored
    function automatic arp_request_t query(logic [IP_W-1:0] qip);
        arp_request_t r;
        r            = packet(16'($urandom_range(65535)), $urandom(), random_mac(),
                              $urandom());
        r.op         = OP_RESOLVE;
        r.hw_type    = 16'($urandom_range(65535));
        r.hw_size    = 8'($urandom_range(255));
        r.proto_type = 16'($urandom_range(65535));
        r.proto_size = 8'($urandom_range(255));
        r.query_ip   = qip;
        return r;
    endfunction

    function automatic arp_request_t random_request();
        arp_request_t r;
        logic [15:0]  opc;
        logic [IP_W-1:0] tip;
        int           roll;
        if ($urandom_range(99) < 35) return query(pick_ip());
        roll = $urandom_range(99);
        if (roll < 50) opc = OPC_REQUEST;
        else if (roll < 80) opc = OPC_REPLY;
        else opc = 16'($urandom_range(65535));
        tip = ($urandom_range(99) < 65) ? sb.local_ip : pick_ip();
        r = packet(opc, pick_ip(), random_mac(), tip);
        // a share of broken headers, one field off at a time
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: r.hw_type    = 16'($urandom_range(65535));
                1: r.hw_size    = 8'($urandom_range(255));
                2: r.proto_type = 16'($urandom_range(65535));
                default: r.proto_size = 8'($urandom_range(255));
            endcase
        end
        return r;
    endfunction

    initial begin
        arp_request_t r;
        foreach (ip_pool[i]) ip_pool[i] = $urandom();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        set_addresses(HOME_IP, HOME_MAC);

        // directed part, no idling
        // resolves on an empty cache: broadcast requests
        send_request(query(32'h0000_0000));
        send_request(query(32'hffff_ffff));
        // header checks, hardware first
        r = packet(OPC_REQUEST, 32'h0a00_0009, random_mac(), HOME_IP);
        r.hw_type = 16'hffff;
        send_request(r);
        r.hw_type = HW_TYPE_ETH;
        r.hw_size = 8'hff;
        send_request(r);
        r.hw_type    = 16'h0000;
        r.hw_size    = HW_SIZE_ETH;
        r.proto_type = 16'hffff;
        send_request(r);
        r.hw_type = HW_TYPE_ETH;
        send_request(r);
        r.proto_type = PROTO_TYPE_IPV4;
        r.proto_size = 8'hff;
        send_request(r);
        r.proto_size = 8'h00;
        send_request(r);
        // request to us from an unknown sender: answered and learnt
        send_request(packet(OPC_REQUEST, 32'h0000_0000, 48'h0, HOME_IP));
        send_request(query(32'h0000_0000));
        // reply to us: learnt, nothing sent
        send_request(packet(OPC_REPLY, 32'hffff_ffff, '1, HOME_IP));
        send_request(query(32'hffff_ffff));
        // unknown opcodes to us: still learnt
        send_request(packet(16'h0000, 32'hc0a8_0a10, 48'h1234_5678_9abc, HOME_IP));
        send_request(packet(16'hffff, 32'h0a00_0001, 48'h8000_0000_0001, HOME_IP));
        // not ours from an unknown sender: nothing learnt
        send_request(packet(OPC_REQUEST, 32'hac10_0005, 48'h0000_1111_2222, HOME_IP ^ 32'h1));
        send_request(query(32'hac10_0005));
        // not ours from a known sender: its mac is refreshed anyway
        send_request(packet(OPC_REPLY, 32'h0000_0000, 48'h5555_aaaa_5555, 32'h0a0a_0a0a));
        send_request(query(32'h0000_0000));
        // request to us from a known sender: refresh without a second entry
        send_request(packet(OPC_REQUEST, 32'hffff_ffff, 48'haaaa_5555_aaaa, HOME_IP));
        send_request(query(32'hffff_ffff));
        send_request(query(32'hc0a8_0a10));
        // broken header from a known sender must leave its entry alone
        r = packet(OPC_REQUEST, 32'hc0a8_0a10, 48'hdead_beef_0000, HOME_IP);
        r.hw_size = 8'd5;
        send_request(r);
        send_request(query(32'hc0a8_0a10));
        settle();

        // random part, one register setting and one idling pattern per phase
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_addresses('0, '0);
                end
                1: begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                    set_addresses('1, '1);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                    set_addresses(ip_pool[0], random_mac());
                end
                3: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                    set_addresses($urandom(), random_mac());
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_addresses(HOME_IP, HOME_MAC);
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_request(random_request());
            settle();
        end

        if (sb.errors == 0) begin
            $display("tb_arp_responder_with_cache_top: clean");
        end else begin
            $display("tb_arp_responder_with_cache_top: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/arprc_pkg.sv
rtl/arprc_ctrl.sv
rtl/arprc_dp.sv
rtl/arp_responder_with_cache_top.sv
test/tb_arp_responder_with_cache_top.sv
